// ----- sv/vfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// vfsm_pkg: shared types and constants of the vector field smoother
// Sizes, fixed-point widths, coefficients and the bundles passed between units.
// ----------------------------------------------------------------------------
package vfsm_pkg;

    localparam int MAX_DIM    = 64;
    localparam int DATA_WIDTH = 16;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_SLOW = 2'd0,
        CFG_SIZE_MID  = 2'd1,
        CFG_SIZE_FAST = 2'd2
    } t_cfg_idx;

    localparam logic CMD_VOXEL = 1'b0;

    // geometry widths
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CRD_W       = $clog2(MAX_DIM);
    localparam int PW          = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int COUNT_W     = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + MAX_DIM * MAX_DIM);
    localparam int PLANE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ROW_DEPTH   = MAX_DIM;
    localparam int PADDR_W     = $clog2(PLANE_DEPTH);
    localparam int RADDR_W     = $clog2(ROW_DEPTH);

    // arithmetic: Q0.16 coefficients, centre weight is a shift
    localparam int SUM_W        = DATA_WIDTH + 3;
    localparam int COEF_FRAC    = 16;
    localparam int COEF_W       = 14;
    localparam int PROD_W       = SUM_W + COEF_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int CENTRE_SHIFT = COEF_FRAC - 1;
    localparam logic signed [COEF_W-1:0] COEF_NEIGH = 14'sd5461;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } t_vox;

    localparam int VOX_W = $bits(t_vox);

    typedef struct packed {
        t_vox centre;
        t_vox m_plane;
        t_vox m_row;
        t_vox m_one;
        t_vox p_one;
        t_vox p_row;
        t_vox p_plane;
    } t_window;

    typedef struct packed {
        logic interior;
        logic last;
    } t_tag;

    typedef struct packed {
        logic               clear;
        logic [PADDR_W-1:0] plane_lim;
        logic [RADDR_W-1:0] row_lim;
    } t_dline_cfg;

    // a zero size acts as one, an oversize acts as the maximum
    function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [DIM_W-1:0] v;
        if (r == '0) begin
            v = DIM_W'(1);
        end else if (32'(r) > MAX_DIM) begin
            v = DIM_W'(MAX_DIM);
        end else begin
            v = DIM_W'(r);
        end
        return v;
    endfunction

endpackage

// ----- sv/vfsm_if.sv -----
// ----------------------------------------------------------------------------
// vfsm_if: channel interfaces of the vector field smoother
// Voxel input, smoothed result output and configuration write channel.
// ----------------------------------------------------------------------------
interface vfsm_in_if import vfsm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [DATA_WIDTH-1:0] in_x;
    logic signed [DATA_WIDTH-1:0] in_y;
    logic signed [DATA_WIDTH-1:0] in_z;

    modport source (output valid, cmd, in_x, in_y, in_z, input ready);
    modport sink   (input valid, cmd, in_x, in_y, in_z, output ready);
endinterface

interface vfsm_out_if import vfsm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic                         interior;
    logic                         last_voxel;

    modport source (output valid, out_x, out_y, out_z, interior, last_voxel, input ready);
    modport sink   (input valid, out_x, out_y, out_z, interior, last_voxel, output ready);
endinterface

interface vfsm_cfg_if import vfsm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/vector_field_seven_point_smoother.sv -----
// Throughput: one item per cycle, set by the single-port delay RAMs; a stalled output handshake holds the input.
// The result for voxel e is registered after the item at stream position e + mid*fast is
// accepted, through the window capture, neighbour sum and weighted sum registers in turn.
// Reset (synchronous, active low): sizes return to 64, position counters, ring pointers
// and pipeline valids clear; delay RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// vector_field_seven_point_smoother: 3D seven-point smoother for a vector field
// Raster voxel stream in, one result per voxel out, one plane late.
// ----------------------------------------------------------------------------
module vector_field_seven_point_smoother import vfsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vfsm_in_if.sink    i_in,
    vfsm_out_if.source o_out,
    vfsm_cfg_if.sink   i_cfg
);

    logic       w_take;
    logic       w_step;
    logic       w_keep;
    logic       w_emit;
    t_tag       w_tag;
    t_dline_cfg w_dl;
    t_vox       w_cur;
    t_window    w_win;

    assign i_in.ready = w_take;
    assign w_step     = i_in.valid & w_take;

    // padding and tail items enter the delay lines as zero
    always_comb begin
        w_cur.x = w_keep ? i_in.in_x : '0;
        w_cur.y = w_keep ? i_in.in_y : '0;
        w_cur.z = w_keep ? i_in.in_z : '0;
    end

    vfsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_step  (w_step),
        .i_cmd   (i_in.cmd),
        .o_keep  (w_keep),
        .o_emit  (w_emit),
        .o_tag   (w_tag),
        .o_dl    (w_dl)
    );

    vfsm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cur   (w_cur),
        .i_dl    (w_dl),
        .o_win   (w_win)
    );

    vfsm_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step & w_emit),
        .i_win   (w_win),
        .i_tag   (w_tag),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ----- sv/vfsm_ram.sv -----
// ----------------------------------------------------------------------------
// vfsm_ram: single-port synchronous RAM, read before write
// One access per enabled cycle; read data is registered and holds otherwise.
// ----------------------------------------------------------------------------
module vfsm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/vfsm_window.sv -----
// ----------------------------------------------------------------------------
// vfsm_window: plane and row delay lines that build the seven-point window
// Two circular RAMs, each carrying two streams, plus two single-item taps.
// ----------------------------------------------------------------------------
module vfsm_window import vfsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_vox       i_cur,
    input  t_dline_cfg i_dl,
    output t_window    o_win
);

    logic [PADDR_W-1:0] r_pptr;
    logic [RADDR_W-1:0] r_rptr;
    logic [2*VOX_W-1:0] w_plane_wr;
    logic [2*VOX_W-1:0] w_plane_rd;
    logic [2*VOX_W-1:0] w_row_wr;
    logic [2*VOX_W-1:0] w_row_rd;
    t_vox               w_v1;
    t_vox               w_v2;
    t_vox               w_v5;
    t_vox               w_v6;
    t_vox               r_v3;
    t_vox               r_v4;

    // a RAM read lands one item later, so each ring is one entry shorter
    // than the delay it stands for
    assign w_v1 = t_vox'(w_plane_rd[2*VOX_W-1:VOX_W]);
    assign w_v6 = t_vox'(w_plane_rd[VOX_W-1:0]);
    assign w_v2 = t_vox'(w_row_rd[2*VOX_W-1:VOX_W]);
    assign w_v5 = t_vox'(w_row_rd[VOX_W-1:0]);

    assign w_plane_wr = {i_cur, w_v5};
    assign w_row_wr   = {w_v1, r_v4};

    vfsm_ram #(
        .DEPTH(PLANE_DEPTH),
        .WIDTH(2*VOX_W)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_en    (i_step),
        .i_addr  (r_pptr),
        .i_wdata (w_plane_wr),
        .o_rdata (w_plane_rd)
    );

    vfsm_ram #(
        .DEPTH(ROW_DEPTH),
        .WIDTH(2*VOX_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_en    (i_step),
        .i_addr  (r_rptr),
        .i_wdata (w_row_wr),
        .o_rdata (w_row_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_dl.clear) begin
            r_pptr <= '0;
            r_rptr <= '0;
        end else if (i_step) begin
            r_pptr <= (r_pptr == i_dl.plane_lim) ? '0 : r_pptr + 1'b1;
            r_rptr <= (r_rptr == i_dl.row_lim) ? '0 : r_rptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_v3 <= w_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        o_win.centre  = r_v3;
        o_win.m_one   = r_v4;
        o_win.p_one   = w_v2;
        o_win.p_row   = w_v1;
        o_win.p_plane = i_cur;
        o_win.m_row   = w_v5;
        o_win.m_plane = w_v6;
    end

endmodule

// ----- sv/vfsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// vfsm_ctrl: size registers, stream position and result coordinates
// Decides which items carry data, which produce a result and its flags.
// ----------------------------------------------------------------------------
module vfsm_ctrl import vfsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vfsm_cfg_if.sink   i_cfg,
    input  logic       i_step,
    input  logic       i_cmd,
    output logic       o_keep,
    output logic       o_emit,
    output t_tag       o_tag,
    output t_dline_cfg o_dl
);

    logic [CFG_W-1:0]   r_size_slow;
    logic [CFG_W-1:0]   r_size_mid;
    logic [CFG_W-1:0]   r_size_fast;
    logic [COUNT_W-1:0] r_acc;
    logic [COUNT_W-1:0] n_acc;
    logic [CRD_W-1:0]   r_ef;
    logic [CRD_W-1:0]   n_ef;
    logic [CRD_W-1:0]   r_em;
    logic [CRD_W-1:0]   n_em;
    logic [CRD_W-1:0]   r_es;
    logic [CRD_W-1:0]   n_es;

    logic [DIM_W-1:0]   w_s;
    logic [DIM_W-1:0]   w_m;
    logic [DIM_W-1:0]   w_f;
    logic [PW-1:0]      w_p;
    logic [PW-1:0]      w_pdiff;
    logic [COUNT_W-1:0] w_n;
    logic [CRD_W-1:0]   w_s_last;
    logic [CRD_W-1:0]   w_m_last;
    logic [CRD_W-1:0]   w_f_last;
    logic               w_cfg_wr;
    logic               w_cfg_hit;
    logic               w_last;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid & i_cfg.ready;
    assign w_cfg_hit   = w_cfg_wr && (i_cfg.index == CFG_SIZE_SLOW ||
                                      i_cfg.index == CFG_SIZE_MID ||
                                      i_cfg.index == CFG_SIZE_FAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_slow <= SIZE_RESET;
            r_size_mid  <= SIZE_RESET;
            r_size_fast <= SIZE_RESET;
        end else if (w_cfg_wr) begin
            case (i_cfg.index)
                CFG_SIZE_SLOW: r_size_slow <= i_cfg.data;
                CFG_SIZE_MID:  r_size_mid  <= i_cfg.data;
                CFG_SIZE_FAST: r_size_fast <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_s      = eff_size(r_size_slow);
    assign w_m      = eff_size(r_size_mid);
    assign w_f      = eff_size(r_size_fast);
    assign w_p      = PW'(w_m) * PW'(w_f);
    assign w_n      = COUNT_W'(w_s) * COUNT_W'(w_p);
    assign w_pdiff  = w_p - PW'(w_f);
    assign w_s_last = CRD_W'(w_s - 1'b1);
    assign w_m_last = CRD_W'(w_m - 1'b1);
    assign w_f_last = CRD_W'(w_f - 1'b1);

    // the result for voxel e leaves with the item one plane later
    assign o_emit = r_acc >= COUNT_W'(w_p);
    assign o_keep = (r_acc < w_n) && (i_cmd == CMD_VOXEL);
    assign w_last = (r_es == w_s_last) && (r_em == w_m_last) && (r_ef == w_f_last);

    assign o_tag.last     = w_last;
    assign o_tag.interior = (r_ef != '0) && (r_ef != w_f_last) &&
                            (r_em != '0) && (r_em != w_m_last) &&
                            (r_es != '0) && (r_es != w_s_last);

    assign o_dl.clear     = w_cfg_hit;
    assign o_dl.plane_lim = (w_pdiff >= PW'(2)) ? PADDR_W'(w_pdiff - PW'(2)) : '0;
    assign o_dl.row_lim   = (w_f >= DIM_W'(3)) ? RADDR_W'(w_f - DIM_W'(3)) : '0;

    always_comb begin
        n_acc = r_acc;
        n_ef  = r_ef;
        n_em  = r_em;
        n_es  = r_es;
        if (w_cfg_hit) begin
            n_acc = '0;
            n_ef  = '0;
            n_em  = '0;
            n_es  = '0;
        end else if (i_step) begin
            if (o_emit && w_last) begin
                n_acc = '0;
                n_ef  = '0;
                n_em  = '0;
                n_es  = '0;
            end else begin
                n_acc = r_acc + 1'b1;
                if (o_emit) begin
                    if (r_ef == w_f_last) begin
                        n_ef = '0;
                        if (r_em == w_m_last) begin
                            n_em = '0;
                            n_es = r_es + 1'b1;
                        end else begin
                            n_em = r_em + 1'b1;
                        end
                    end else begin
                        n_ef = r_ef + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ef  <= '0;
            r_em  <= '0;
            r_es  <= '0;
        end else begin
            r_acc <= n_acc;
            r_ef  <= n_ef;
            r_em  <= n_em;
            r_es  <= n_es;
        end
    end

endmodule

// ----- sv/vfsm_filter.sv -----
// ----------------------------------------------------------------------------
// vfsm_filter: three-stage smoothing datapath with output register
// Window capture, neighbour sums, weighted sum with rounding.
// ----------------------------------------------------------------------------
module vfsm_filter import vfsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_window    i_win,
    input  t_tag       i_tag,
    output logic       o_take,
    vfsm_out_if.source o_out
);

    logic                         r_s1_valid;
    t_window                      r_s1_win;
    t_tag                         r_s1_tag;
    logic                         r_s2_valid;
    t_vox                         r_s2_centre;
    logic signed [SUM_W-1:0]      r_s2_sx;
    logic signed [SUM_W-1:0]      r_s2_sy;
    logic signed [SUM_W-1:0]      r_s2_sz;
    t_tag                         r_s2_tag;
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_x;
    logic signed [DATA_WIDTH-1:0] r_out_y;
    logic signed [DATA_WIDTH-1:0] r_out_z;
    logic                         r_out_interior;
    logic                         r_out_last;
    logic                         w_take2;
    logic                         w_take3;

    function automatic logic signed [SUM_W-1:0] sum6(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b,
        input logic signed [DATA_WIDTH-1:0] c,
        input logic signed [DATA_WIDTH-1:0] d,
        input logic signed [DATA_WIDTH-1:0] e,
        input logic signed [DATA_WIDTH-1:0] f
    );
        return SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d) + SUM_W'(e) + SUM_W'(f);
    endfunction

    // half the centre plus 5461/65536 of the neighbour sum, round half up
    function automatic logic signed [DATA_WIDTH-1:0] smooth(
        input logic signed [DATA_WIDTH-1:0] c,
        input logic signed [SUM_W-1:0]      s
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        prod = s * COEF_NEIGH;
        acc  = (ACC_W'(c) <<< CENTRE_SHIFT) + ACC_W'(prod) + ROUND_HALF;
        return acc[COEF_FRAC +: DATA_WIDTH];
    endfunction

    assign w_take3 = !r_out_valid || o_out.ready;
    assign w_take2 = !r_s2_valid || w_take3;
    assign o_take  = !r_s1_valid || w_take2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_s1_valid <= i_load;
            end
            if (w_take2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_take3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_load) begin
            r_s1_win <= i_win;
            r_s1_tag <= i_tag;
        end
        if (w_take2 && r_s1_valid) begin
            r_s2_centre <= r_s1_win.centre;
            r_s2_tag    <= r_s1_tag;
            r_s2_sx     <= sum6(r_s1_win.m_plane.x, r_s1_win.m_row.x, r_s1_win.m_one.x,
                                r_s1_win.p_one.x, r_s1_win.p_row.x, r_s1_win.p_plane.x);
            r_s2_sy     <= sum6(r_s1_win.m_plane.y, r_s1_win.m_row.y, r_s1_win.m_one.y,
                                r_s1_win.p_one.y, r_s1_win.p_row.y, r_s1_win.p_plane.y);
            r_s2_sz     <= sum6(r_s1_win.m_plane.z, r_s1_win.m_row.z, r_s1_win.m_one.z,
                                r_s1_win.p_one.z, r_s1_win.p_row.z, r_s1_win.p_plane.z);
        end
        if (w_take3 && r_s2_valid) begin
            // boundary voxels go out as zero
            r_out_x        <= r_s2_tag.interior ? smooth(r_s2_centre.x, r_s2_sx) : '0;
            r_out_y        <= r_s2_tag.interior ? smooth(r_s2_centre.y, r_s2_sy) : '0;
            r_out_z        <= r_s2_tag.interior ? smooth(r_s2_centre.z, r_s2_sz) : '0;
            r_out_interior <= r_s2_tag.interior;
            r_out_last     <= r_s2_tag.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_x      = r_out_x;
    assign o_out.out_y      = r_out_y;
    assign o_out.out_z      = r_out_z;
    assign o_out.interior   = r_out_interior;
    assign o_out.last_voxel = r_out_last;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the seven-point vector field smoother
// A queue-fed driver streams voxel volumes of several shapes through the
// block. A scoreboard predicts every smoothed voxel from its own plane store
// and compares each result field by field, under four idle/stall profiles.
// ----------------------------------------------------------------------------
module tb;
    import vfsm_pkg::*;

    localparam int     STORE_DEPTH    = 2 * MAX_DIM * MAX_DIM;
    localparam longint CENTRE_WEIGHT  = 32768;
    localparam longint NEIGH_WEIGHT   = 5461;
    localparam longint ROUND_BIAS     = 32768;
    localparam int     COEF_SHIFT     = 16;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     HOLDOFF_CYCLES = 400;
    localparam int     MAX_PRINTS     = 40;
    localparam longint RUN_LIMIT_NS   = 4_000_000;

    localparam logic CMD_PAD = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = 16'sh7FFF;
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = 16'sh8000;

    typedef struct packed {
        logic                         cmd;
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } t_voxel_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
        logic                         interior;
        logic                         last_voxel;
    } t_voxel_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vfsm_in_if  voxel_if ();
    vfsm_out_if result_if ();
    vfsm_cfg_if cfg_if ();

    vector_field_seven_point_smoother uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (voxel_if),
        .o_out   (result_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_voxel_item   pending_voxels [$];
    t_voxel_result expected_voxels [$];
    t_voxel_item   next_voxel;

    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        rx_hold;
    event        holdoff_start;

    // scoreboard state
    logic [CFG_W-1:0]             size_reg [3];
    logic signed [DATA_WIDTH-1:0] plane_store [STORE_DEPTH][3];
    int unsigned                  stream_pos;

    function automatic int unsigned active_dim(input logic [CFG_W-1:0] r);
        if (r == '0) return 1;
        if (int'(r) > MAX_DIM) return MAX_DIM;
        return int'(r);
    endfunction

    function automatic int unsigned plane_voxels();
        return active_dim(size_reg[CFG_SIZE_MID]) * active_dim(size_reg[CFG_SIZE_FAST]);
    endfunction

    function automatic int unsigned volume_voxels();
        return active_dim(size_reg[CFG_SIZE_SLOW]) * plane_voxels();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] value);
        case (idx)
            CFG_SIZE_SLOW, CFG_SIZE_MID, CFG_SIZE_FAST: begin
                size_reg[idx] = value;
                stream_pos = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // Advance the stream by one position; queue the smoothed voxel it completes.
    function automatic void take_voxel(input t_voxel_item item);
        int unsigned nfast, nmid, nslow, plane, total, e, f, r, s;
        logic signed [DATA_WIDTH-1:0] cur [3];
        logic signed [DATA_WIDTH-1:0] smoothed [3];
        longint sum6, acc;
        bit inner;
        nfast = active_dim(size_reg[CFG_SIZE_FAST]);
        nmid  = active_dim(size_reg[CFG_SIZE_MID]);
        nslow = active_dim(size_reg[CFG_SIZE_SLOW]);
        plane = nmid * nfast;
        total = nslow * plane;
        cur = '{default: '0};
        smoothed = '{default: '0};
        if (stream_pos < total && item.cmd == CMD_VOXEL) begin
            cur = '{item.x, item.y, item.z};
        end
        if (stream_pos >= plane) begin
            e = stream_pos - plane;
            f = e % nfast;
            r = (e / nfast) % nmid;
            s = e / plane;
            inner = f >= 1 && f + 1 < nfast && r >= 1 && r + 1 < nmid &&
                    s >= 1 && s + 1 < nslow;
            if (inner) begin
                for (int i = 0; i < 3; i++) begin
                    sum6 = longint'(plane_store[(e - plane) % STORE_DEPTH][i])
                         + longint'(plane_store[(e - nfast) % STORE_DEPTH][i])
                         + longint'(plane_store[(e - 1) % STORE_DEPTH][i])
                         + longint'(plane_store[(e + 1) % STORE_DEPTH][i])
                         + longint'(plane_store[(e + nfast) % STORE_DEPTH][i])
                         + longint'(cur[i]);
                    acc = CENTRE_WEIGHT * longint'(plane_store[e % STORE_DEPTH][i])
                        + NEIGH_WEIGHT * sum6 + ROUND_BIAS;
                    smoothed[i] = DATA_WIDTH'(acc >>> COEF_SHIFT);
                end
            end
            expected_voxels.push_back('{x: smoothed[0], y: smoothed[1], z: smoothed[2],
                                        interior: inner, last_voxel: e == total - 1});
            plane_store[stream_pos % STORE_DEPTH] = cur;
            stream_pos = (e == total - 1) ? 0 : stream_pos + 1;
        end else begin
            plane_store[stream_pos % STORE_DEPTH] = cur;
            stream_pos = stream_pos + 1;
        end
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] MISMATCH result %0d: %s", $time, results_checked, what);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [DATA_WIDTH-1:0] got,
                                 input logic [DATA_WIDTH-1:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic check_result();
        t_voxel_result want;
        if (expected_voxels.size() == 0) begin
            flag_mismatch("result with no voxel expected");
        end else begin
            want = expected_voxels.pop_front();
            compare_field("out_x", result_if.out_x, want.x);
            compare_field("out_y", result_if.out_y, want.y);
            compare_field("out_z", result_if.out_z, want.z);
            compare_field("interior", result_if.interior, want.interior);
            compare_field("last_voxel", result_if.last_voxel, want.last_voxel);
        end
        results_checked++;
    endtask

    // monitor: sample every handshake at the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
            stream_pos = 0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                apply_register(cfg_if.index, cfg_if.data);
            end
            if (voxel_if.valid && voxel_if.ready) begin
                items_taken++;
                take_voxel('{cmd: voxel_if.cmd, x: voxel_if.in_x, y: voxel_if.in_y,
                             z: voxel_if.in_z});
            end
            if (result_if.valid && result_if.ready) begin
                check_result();
            end
        end
    end

    // driver: present the next item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            voxel_if.valid <= 1'b0;
        end else if (!voxel_if.valid || voxel_if.ready) begin
            if (pending_voxels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_voxel = pending_voxels.pop_front();
                voxel_if.valid <= 1'b1;
                voxel_if.cmd   <= next_voxel.cmd;
                voxel_if.in_x  <= next_voxel.x;
                voxel_if.in_y  <= next_voxel.y;
                voxel_if.in_z  <= next_voxel.z;
            end else begin
                voxel_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        rx_hold = 1'b0;
        forever begin
            @(holdoff_start);
            rx_hold <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] random_component();
        case ($urandom_range(7))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return DATA_WIDTH'($urandom_range(64)) - DATA_WIDTH'(32);
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic void queue_item(input logic cmd, input logic signed [DATA_WIDTH-1:0] x,
                                       input logic signed [DATA_WIDTH-1:0] y,
                                       input logic signed [DATA_WIDTH-1:0] z);
        pending_voxels.push_back('{cmd: cmd, x: x, y: y, z: z});
        items_queued++;
    endfunction

    // mostly real voxels, a few padding items inside the volume
    function automatic void queue_voxels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            queue_item(($urandom_range(99) < 8) ? CMD_PAD : CMD_VOXEL,
                       random_component(), random_component(), random_component());
        end
    endfunction

    // push the last plane out; data here is ignored
    function automatic void queue_tail();
        for (int unsigned i = 0; i < plane_voxels(); i++) begin
            queue_item(1'($urandom), random_component(), random_component(),
                       random_component());
        end
    endfunction

    function automatic void queue_volume();
        queue_voxels(volume_voxels());
        queue_tail();
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] slow, input logic [CFG_W-1:0] mid,
                             input logic [CFG_W-1:0] fast);
        write_register(CFG_SIZE_SLOW, slow);
        write_register(CFG_SIZE_MID, mid);
        write_register(CFG_SIZE_FAST, fast);
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || expected_voxels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        voxel_if.valid = 1'b0;
        voxel_if.cmd   = CMD_VOXEL;
        voxel_if.in_x  = '0;
        voxel_if.in_y  = '0;
        voxel_if.in_z  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = CFG_SIZE_SLOW;
        cfg_if.data    = '0;
        result_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest cube with an interior voxel: full-scale neighbours, rounding tie on z
        set_sizes(7'd3, 7'd3, 7'd3);
        for (int unsigned p = 0; p < 27; p++) begin
            if (p == 13) begin
                queue_item(CMD_VOXEL, DATA_MAX, DATA_MIN, -16'sd1);
            end else if (p == 4 || p == 10 || p == 12 || p == 14 || p == 16 || p == 22) begin
                queue_item(CMD_VOXEL, DATA_MAX, DATA_MIN, '0);
            end else if (p == 0 || p == 26) begin
                queue_item(CMD_PAD, random_component(), random_component(),
                           random_component());
            end else begin
                queue_item(CMD_VOXEL, DATA_MIN, DATA_MAX, random_component());
            end
        end
        queue_tail();
        wait_idle();

        // no idling; pause mid-volume and write an unmapped index
        set_sizes(7'd4, 7'd5, 7'd6);
        queue_voxels(53);
        wait_idle();
        write_register(CFG_IDX_UNUSED, 7'h7F);
        queue_voxels(volume_voxels() - 53);
        queue_tail();
        wait_idle();
        // hold the output off so the block backs up into its input
        -> holdoff_start;
        queue_volume();
        wait_idle();

        send_idle_pct = 78;
        set_sizes(7'd127, 7'd0, 7'd1);
        repeat (2) queue_volume();
        wait_idle();
        set_sizes(7'd1, 7'd64, 7'd1);
        queue_volume();
        wait_idle();

        send_idle_pct = 0;
        recv_stall_pct = 78;
        set_sizes(7'd6, 7'd4, 7'd3);
        repeat (2) queue_volume();
        wait_idle();
        // leave a pass unfinished; the next size write aborts it
        queue_voxels(40);
        wait_idle();

        send_idle_pct = 28;
        recv_stall_pct = 28;
        set_sizes(7'd3, 7'd3, 7'd64);
        queue_volume();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[%0t] timeout: %0d of %0d items taken, %0d results pending",
                 $time, items_taken, items_queued, expected_voxels.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- vector_field_seven_point_smoother.f -----
sv/vfsm_pkg.sv
sv/vfsm_if.sv
sv/vfsm_ram.sv
sv/vfsm_window.sv
sv/vfsm_ctrl.sv
sv/vfsm_filter.sv
sv/vector_field_seven_point_smoother.sv
dv/tb.sv
